@@ design/foc_current_loop_step_macros.svh @@
// Assertion macros used by the current loop top-level design file.
`ifndef FOC_CURRENT_LOOP_STEP_MACROS_SVH
`define FOC_CURRENT_LOOP_STEP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FOC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("current loop check failed");

// Next-cycle implication, checked outside reset.
`define FOC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("current loop check failed");

`endif

@@ design/foc_pkg.sv @@
// Package: shared types, codes and fixed constants of the current loop.
`timescale 1ns / 1ps
`default_nettype none
package foc_pkg;

    // sine polynomial coefficients, Q30
    localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
    localparam logic signed [31:0] SIN_C3 = 32'sd693598668;
    localparam logic signed [31:0] SIN_C5 = 32'sd85569306;
    localparam logic signed [31:0] SIN_C7 = 32'sd5026995;
    localparam logic signed [31:0] SIN_C9 = 32'sd172272;
    localparam logic signed [31:0] INV_SQRT3 = 32'sd619925131;
    localparam logic signed [31:0] SQRT3_HALF = 32'sd929887697;
    localparam logic signed [31:0] HALF_Q30 = 32'sd536870912;

    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_REF_D     = 3'd0,
        REG_REF_Q     = 3'd1,
        REG_GAIN_P    = 3'd2,
        REG_GAIN_I_DT = 3'd3,
        REG_DRIVE_MIN = 3'd4,
        REG_DRIVE_MAX = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        OP_RUN   = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    typedef enum logic [5:0] {
        S_SN_U2, S_SN_T7, S_SN_T5, S_SN_T3, S_SN_T1, S_SN_OUT,
        S_CS_U2, S_CS_T7, S_CS_T5, S_CS_T3, S_CS_T1, S_CS_OUT,
        S_BETA, S_MD0, S_MD1, S_MQ0, S_MQ1,
        S_PD, S_ID, S_DD, S_PQ, S_IQ, S_DQ,
        S_VA0, S_VA1, S_VB0, S_VB1,
        S_VOB0, S_VOB1, S_VOC0, S_VOC1
    } step_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic chain;
    } mac_ctrl_t;

endpackage
`default_nettype wire

@@ design/foc_in_if.sv @@
// Interface: input channel of the current loop.
`timescale 1ns / 1ps
`default_nettype none
interface foc_in_if #(
    parameter int DATA_WIDTH  = 16,
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [DATA_WIDTH-1:0]  current_a;
    logic signed [DATA_WIDTH-1:0]  current_b;
    logic        [ANGLE_WIDTH-1:0] angle;

    modport source (output valid, op, current_a, current_b, angle, input ready);
    modport sink (input valid, op, current_a, current_b, angle, output ready);
endinterface
`default_nettype wire

@@ design/foc_out_if.sv @@
// Interface: result channel of the current loop.
`timescale 1ns / 1ps
`default_nettype none
interface foc_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] meas_d;
    logic signed [DATA_WIDTH-1:0] meas_q;
    logic signed [DATA_WIDTH-1:0] drive_d;
    logic signed [DATA_WIDTH-1:0] drive_q;
    logic signed [DATA_WIDTH-1:0] volt_a;
    logic signed [DATA_WIDTH-1:0] volt_b;
    logic signed [DATA_WIDTH-1:0] volt_c;

    modport source (output valid, meas_d, meas_q, drive_d, drive_q, volt_a, volt_b, volt_c,
                    input ready);
    modport sink (input valid, meas_d, meas_q, drive_d, drive_q, volt_a, volt_b, volt_c,
                  output ready);
endinterface
`default_nettype wire

@@ design/foc_current_loop_step.sv @@
// Top level: field-oriented current loop step on one shared multiply-accumulate unit.
// Usage:
//   in_ch carries op, current_a, current_b and angle; a transfer happens when valid
//   and ready are both high. ready is high only while the block is idle.
//   op = clear: both integrators drop to zero in the transfer cycle, no result.
//   op = run: 31 micro steps go through one multiplier and one accumulator; each step
//   multiplies, then accumulates and writes back; out_ch.valid rises once the last
//   step has been written back. The next input transfer is accepted only after the
//   output transfer, when the block is idle again.
//   out_ch holds the seven result fields until the receiver takes them; while the
//   receiver stalls the block holds the result and takes no new input.
//   Configuration: cfg_we writes cfg_data into register cfg_index at the clock
//   edge; indexes past the last register are ignored. Write only while idle.
//   Reset (rst_n low, asynchronous) clears both integrators, restores the register
//   defaults and returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none
module foc_current_loop_step import foc_pkg::*; #(
    parameter int DATA_WIDTH  = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    foc_in_if.sink                             in_ch,
    foc_out_if.source                          out_ch,
    input  wire                                cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [((DATA_WIDTH > 16) ? DATA_WIDTH : 16)-1:0] cfg_data
);
    localparam int DW   = DATA_WIDTH;
    localparam int AW   = ANGLE_WIDTH;
    localparam int F    = DW - 1;
    localparam int OPW  = (DW + 10 > 32) ? DW + 10 : 32;
    localparam int ACCW = 2 * OPW + 2;
    localparam int IW   = DW + 16;
    localparam int PW   = DW + 9;

    localparam logic signed [DW-1:0]   DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0]   DMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [ACCW-1:0] RND_F   = ACCW'(1) <<< (F - 1);
    localparam logic signed [ACCW-1:0] RND_8   = ACCW'(128);
    localparam logic signed [ACCW-1:0] RND_30  = ACCW'(1) <<< 29;
    localparam logic signed [ACCW-1:0] RND_SIN = ACCW'(1) <<< (59 - F);
    localparam logic signed [OPW-1:0]  HALF_16 = OPW'(32768);
    localparam logic [AW-1:0]          QUARTER = AW'(1) << (AW - 2);
    localparam logic [30:0]            ONE_Q30 = 31'(1) << 30;

    function automatic logic signed [DW-1:0] sat_d(input logic signed [ACCW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > ACCW'(DMAX))
        begin
            r = DMAX;
        end
        else if (v < ACCW'(DMIN))
        begin
            r = DMIN;
        end
        else
        begin
            r = DW'(v);
        end
        return r;
    endfunction

    // upper bound first, then lower bound
    function automatic logic signed [ACCW-1:0] clamp_w(input logic signed [ACCW-1:0] v,
                                                      input logic signed [ACCW-1:0] lo,
                                                      input logic signed [ACCW-1:0] hi);
        logic signed [ACCW-1:0] r;
        r = (v > hi) ? hi : v;
        r = (r < lo) ? lo : r;
        return r;
    endfunction

    // configuration registers
    logic signed [DW-1:0] ref_d_reg, ref_q_reg, dmin_reg, dmax_reg;
    logic        [15:0]   gain_p_reg, gain_i_reg;

    // sequencer
    state_t state_reg, state_next;
    step_t  step_reg;
    logic   phase_reg;
    logic   in_accept, run_accept, clr_accept, wb_en, last_step;
    logic   mac_chain;
    mac_ctrl_t mac_ctrl;

    // captured inputs and working values
    logic signed [DW-1:0]   ia_reg, ib_reg;
    logic        [AW-1:0]   ang_reg;
    logic signed [OPW-1:0]  u2_reg, t_reg;
    logic signed [DW-1:0]   sn_reg, cs_reg;
    logic signed [DW:0]     beta_reg;
    logic signed [DW-1:0]   md_reg, mq_reg, drive_d_reg, drive_q_reg;
    logic signed [PW-1:0]   p_reg;
    logic signed [IW-1:0]   integ_d_reg, integ_q_reg;
    logic signed [DW+1:0]   va_reg, vb_reg;
    logic signed [DW-1:0]   volt_a_reg, volt_b_reg, volt_c_reg;

    // shared unit ports
    logic signed [OPW-1:0]  op_a, op_b;
    logic signed [ACCW-1:0] bias, sum;

    // sine argument
    logic          cs_sel;
    logic [AW-1:0] ph;
    logic [1:0]    quad;
    logic [29:0]   u_shift;
    logic [30:0]   u_val;
    logic signed [ACCW-1:0] sine_s;
    logic signed [DW-1:0]   sine_v, sine_out;

    logic signed [DW:0]     err_d, err_q;
    logic signed [ACCW-1:0] sh8, sh16, sh30, shf, lo16, hi16, lo_w, hi_w;

    // ---------------- configuration port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_d_reg  <= '0;
            ref_q_reg  <= '0;
            gain_p_reg <= 16'd256;
            gain_i_reg <= '0;
            dmin_reg   <= DMIN;
            dmax_reg   <= DMAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_REF_D:     ref_d_reg  <= DW'(cfg_data);
                REG_REF_Q:     ref_q_reg  <= DW'(cfg_data);
                REG_GAIN_P:    gain_p_reg <= cfg_data[15:0];
                REG_GAIN_I_DT: gain_i_reg <= cfg_data[15:0];
                REG_DRIVE_MIN: dmin_reg   <= DW'(cfg_data);
                REG_DRIVE_MAX: dmax_reg   <= DW'(cfg_data);
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign in_accept  = in_ch.valid && in_ch.ready;
    assign run_accept = in_accept && (op_t'(in_ch.op) == OP_RUN);
    assign clr_accept = in_accept && (op_t'(in_ch.op) == OP_CLEAR);
    assign last_step  = (step_reg == S_VOC1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (run_accept) state_next = ST_RUN;
            ST_RUN:  if (phase_reg && last_step) state_next = ST_OUT;
            ST_OUT:  if (out_ch.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready     = 1'b0;
        out_ch.valid    = 1'b0;
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.acc_en = 1'b0;
        mac_ctrl.chain  = mac_chain;
        wb_en           = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ch.ready = 1'b1;
            ST_RUN:
            begin
                mac_ctrl.mul_en = !phase_reg;
                mac_ctrl.acc_en = phase_reg;
                wb_en           = phase_reg;
            end
            ST_OUT:  out_ch.valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= S_SN_U2;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (run_accept)
            begin
                step_reg  <= S_SN_U2;
                phase_reg <= 1'b0;
            end
            else if (state_reg == ST_RUN)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg && !last_step)
                begin
                    step_reg <= step_t'(step_reg + 6'd1);
                end
            end
        end
    end

    // ---------------- operand selection ----------------
    always_comb
    begin
        case (step_reg) inside
            S_CS_U2, S_CS_T7, S_CS_T5, S_CS_T3, S_CS_T1, S_CS_OUT: cs_sel = 1'b1;
            default: cs_sel = 1'b0;
        endcase
    end

    assign ph      = cs_sel ? (ang_reg + QUARTER) : ang_reg;
    assign quad    = ph[AW-1:AW-2];
    assign u_shift = {ph[AW-3:0], {(32-AW){1'b0}}};
    assign u_val   = quad[0] ? (ONE_Q30 - 31'(u_shift)) : 31'(u_shift);

    assign err_d = (DW+1)'(ref_d_reg) - (DW+1)'(md_reg);
    assign err_q = (DW+1)'(ref_q_reg) - (DW+1)'(mq_reg);

    always_comb
    begin
        op_a      = '0;
        op_b      = '0;
        bias      = '0;
        mac_chain = 1'b0;
        unique case (step_reg) inside
            S_SN_U2, S_CS_U2:
            begin
                op_a = OPW'($signed({1'b0, u_val}));
                op_b = OPW'($signed({1'b0, u_val}));
            end
            S_SN_T7, S_CS_T7:
            begin
                op_a = u2_reg;
                op_b = OPW'(SIN_C9);
            end
            S_SN_T5, S_CS_T5, S_SN_T3, S_CS_T3, S_SN_T1, S_CS_T1:
            begin
                op_a = u2_reg;
                op_b = t_reg;
            end
            S_SN_OUT, S_CS_OUT:
            begin
                op_a = OPW'($signed({1'b0, u_val}));
                op_b = t_reg;
                bias = RND_SIN;
            end
            S_BETA:
            begin
                op_a = OPW'(ia_reg) + (OPW'(ib_reg) <<< 1);
                op_b = OPW'(INV_SQRT3);
                bias = RND_30;
            end
            S_MD0:
            begin
                op_a = OPW'(ia_reg);
                op_b = OPW'(cs_reg);
                bias = RND_F;
            end
            S_MD1:
            begin
                op_a = OPW'(beta_reg);
                op_b = OPW'(sn_reg);
                mac_chain = 1'b1;
            end
            S_MQ0:
            begin
                op_a = OPW'(beta_reg);
                op_b = OPW'(cs_reg);
                bias = RND_F;
            end
            S_MQ1:
            begin
                op_a = -OPW'(ia_reg);
                op_b = OPW'(sn_reg);
                mac_chain = 1'b1;
            end
            S_PD:
            begin
                op_a = OPW'(err_d);
                op_b = OPW'($signed({1'b0, gain_p_reg}));
                bias = RND_8;
            end
            S_ID:
            begin
                op_a = OPW'(err_d);
                op_b = OPW'($signed({1'b0, gain_i_reg}));
                bias = ACCW'(integ_d_reg);
            end
            S_DD:
            begin
                // (2p + 1) * 2^15 = p * 2^16 plus the rounding half
                op_a = (OPW'(p_reg) <<< 1) + OPW'(1);
                op_b = HALF_16;
                bias = ACCW'(integ_d_reg);
            end
            S_PQ:
            begin
                op_a = OPW'(err_q);
                op_b = OPW'($signed({1'b0, gain_p_reg}));
                bias = RND_8;
            end
            S_IQ:
            begin
                op_a = OPW'(err_q);
                op_b = OPW'($signed({1'b0, gain_i_reg}));
                bias = ACCW'(integ_q_reg);
            end
            S_DQ:
            begin
                op_a = (OPW'(p_reg) <<< 1) + OPW'(1);
                op_b = HALF_16;
                bias = ACCW'(integ_q_reg);
            end
            S_VA0:
            begin
                op_a = OPW'(drive_d_reg);
                op_b = OPW'(cs_reg);
                bias = RND_F;
            end
            S_VA1:
            begin
                op_a = -OPW'(drive_q_reg);
                op_b = OPW'(sn_reg);
                mac_chain = 1'b1;
            end
            S_VB0:
            begin
                op_a = OPW'(drive_d_reg);
                op_b = OPW'(sn_reg);
                bias = RND_F;
            end
            S_VB1:
            begin
                op_a = OPW'(drive_q_reg);
                op_b = OPW'(cs_reg);
                mac_chain = 1'b1;
            end
            S_VOB0, S_VOC0:
            begin
                op_a = -OPW'(va_reg);
                op_b = OPW'(HALF_Q30);
                bias = RND_30;
            end
            S_VOB1:
            begin
                op_a = OPW'(vb_reg);
                op_b = OPW'(SQRT3_HALF);
                mac_chain = 1'b1;
            end
            S_VOC1:
            begin
                op_a = -OPW'(vb_reg);
                op_b = OPW'(SQRT3_HALF);
                mac_chain = 1'b1;
            end
            default: ;
        endcase
    end

    foc_mac #(
        .OPW  (OPW),
        .ACCW (ACCW)
    ) u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .bias (bias),
        .sum  (sum)
    );

    // ---------------- write back ----------------
    assign sh8  = sum >>> 8;
    assign sh16 = sum >>> 16;
    assign sh30 = sum >>> 30;
    assign shf  = sum >>> F;
    assign lo_w = ACCW'(dmin_reg);
    assign hi_w = ACCW'(dmax_reg);
    assign lo16 = lo_w <<< 16;
    assign hi16 = hi_w <<< 16;

    // sine result: cap at full scale, mirror for the lower half turn
    assign sine_s   = sum >>> (60 - F);
    assign sine_v   = (sine_s > ACCW'(DMAX)) ? DMAX : DW'(sine_s);
    assign sine_out = quad[1] ? -sine_v : sine_v;

    always_ff @(posedge clk)
    begin
        if (run_accept)
        begin
            ia_reg  <= in_ch.current_a;
            ib_reg  <= in_ch.current_b;
            ang_reg <= in_ch.angle;
        end
        if (wb_en)
        begin
            case (step_reg) inside
                S_SN_U2, S_CS_U2: u2_reg <= OPW'(sh30);
                S_SN_T7, S_CS_T7: t_reg <= OPW'(SIN_C7) - OPW'(sh30);
                S_SN_T5, S_CS_T5: t_reg <= OPW'(SIN_C5) - OPW'(sh30);
                S_SN_T3, S_CS_T3: t_reg <= OPW'(SIN_C3) - OPW'(sh30);
                S_SN_T1, S_CS_T1: t_reg <= OPW'(SIN_C1) - OPW'(sh30);
                S_SN_OUT:         sn_reg <= sine_out;
                S_CS_OUT:         cs_reg <= sine_out;
                S_BETA:           beta_reg <= (DW+1)'(sh30);
                S_MD1:            md_reg <= sat_d(shf);
                S_MQ1:            mq_reg <= sat_d(shf);
                S_PD, S_PQ:       p_reg <= PW'(sh8);
                S_DD:             drive_d_reg <= DW'(clamp_w(sh16, lo_w, hi_w));
                S_DQ:             drive_q_reg <= DW'(clamp_w(sh16, lo_w, hi_w));
                S_VA1:
                begin
                    va_reg     <= (DW+2)'(shf);
                    volt_a_reg <= sat_d(shf);
                end
                S_VB1:            vb_reg <= (DW+2)'(shf);
                S_VOB1:           volt_b_reg <= sat_d(sh30);
                S_VOC1:           volt_c_reg <= sat_d(sh30);
                default: ;
            endcase
        end
    end

    // integrators: clamp to the drive limits scaled by 2^16
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_d_reg <= '0;
            integ_q_reg <= '0;
        end
        else if (clr_accept)
        begin
            integ_d_reg <= '0;
            integ_q_reg <= '0;
        end
        else if (wb_en && (step_reg == S_ID))
        begin
            integ_d_reg <= IW'(clamp_w(sum, lo16, hi16));
        end
        else if (wb_en && (step_reg == S_IQ))
        begin
            integ_q_reg <= IW'(clamp_w(sum, lo16, hi16));
        end
    end

    // ---------------- result channel ----------------
    assign out_ch.meas_d  = md_reg;
    assign out_ch.meas_q  = mq_reg;
    assign out_ch.drive_d = drive_d_reg;
    assign out_ch.drive_q = drive_q_reg;
    assign out_ch.volt_a  = volt_a_reg;
    assign out_ch.volt_b  = volt_b_reg;
    assign out_ch.volt_c  = volt_c_reg;

    // ---------------- assertions ----------------
`include "foc_current_loop_step_macros.svh"
    `FOC_ASSERT_IMP(a_one_item, out_ch.valid, !in_ch.ready)
    `FOC_ASSERT_NEXT(a_clear_zeroes, clr_accept, (integ_d_reg == '0) && (integ_q_reg == '0))
    `FOC_ASSERT_NEXT(a_run_starts, run_accept,
                     (state_reg == ST_RUN) && (step_reg == S_SN_U2) && !phase_reg)
    `FOC_ASSERT_IMP(a_drive_in_limits, out_ch.valid && (dmin_reg <= dmax_reg),
                    (drive_d_reg >= dmin_reg) && (drive_d_reg <= dmax_reg) &&
                    (drive_q_reg >= dmin_reg) && (drive_q_reg <= dmax_reg))
endmodule
`default_nettype wire

@@ design/foc_mac.sv @@
// Shared multiply-accumulate unit: registered product, then one wide add.
`timescale 1ns / 1ps
`default_nettype none
module foc_mac import foc_pkg::*; #(
    parameter int OPW  = 32,
    parameter int ACCW = 66
) (
    input  wire                         clk,
    input  wire mac_ctrl_t              ctrl,
    input  wire logic signed [OPW-1:0]  op_a,
    input  wire logic signed [OPW-1:0]  op_b,
    input  wire logic signed [ACCW-1:0] bias,
    output logic signed [ACCW-1:0]      sum
);
    logic signed [2*OPW-1:0] prod_reg;
    logic signed [ACCW-1:0]  acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= op_a * op_b;
        end
        if (ctrl.acc_en)
        begin
            acc_reg <= sum;
        end
    end

    // chain onto the previous sum, or start from the given bias
    assign sum = (ctrl.chain ? acc_reg : bias) + ACCW'(prod_reg);
endmodule
`default_nettype wire
